// ===== hw/rtl/scd_pkg.sv =====
// ---------------------------------------------------------------------------
// scd_pkg: shared widths and types for the spi clock divider search
// Holds the datapath widths and the request and response bundles that pass
// between the sequencer and the serial divider.
// ---------------------------------------------------------------------------
package scd_pkg;

  localparam int SRC_W      = 28;  // source clock and achieved rate
  localparam int TGT_W      = 32;  // requested bus rate
  localparam int DIV_CODE_W = 3;   // divisor code 0, 2, 3 or 5
  localparam int DIVIDEND_W = 29;  // holds the source clock plus a small offset
  localparam int DIVISOR_W  = 32;  // holds target times divisor

  typedef struct packed {
    logic                  go;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/scd_divider.sv =====
// ---------------------------------------------------------------------------
// scd_divider: serial restoring divider
// One quotient bit per cycle; done pulses for one cycle when the quotient
// is ready and it holds until the next launch.
// ---------------------------------------------------------------------------
module scd_divider (
  input  logic              clk,
  input  logic              rst,
  input  scd_pkg::div_req_t req,
  output scd_pkg::div_rsp_t rsp
);
  import scd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // shifted stays below twice the divisor, so the top bit of diff is its sign
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_go_idle: assert property (@(posedge clk) disable iff (rst) req.go |-> !busy)
    else $error("divider launched while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.go && cnt == CNT_W'(1)) |=> (done && !busy))
    else $error("divider did not finish after its last step");
  a_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

// ===== hw/rtl/spi_clock_divider_search.sv =====
// ---------------------------------------------------------------------------
// spi_clock_divider_search: spi bus clock setting search
// Finds divisor and prescaler so that the bus rate never exceeds the
// requested rate, using one shared serial divider under a small sequencer.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | word
//  --------+------------------------+-------------------------------------
//  cfg     | cfg_valid / cfg_ready  | source_clock_hz
//  req     | req_valid / req_stall  | target_freq
//  rsp     | rsp_valid / rsp_stall  | use_sysclk .. prescale_overflow
//
//  a request at or above the source clock gives its result in the cycle after
//  acceptance; otherwise each division runs on the serial divider,
//  4 divisions when divisor 2 hits the target and 10 when
//  divisors 3 and 5 are also tried
//  one request at a time: req_stall stays high from acceptance until the
//  result word is taken; rsp_stall holds the result as long as needed
//  synchronous reset sets the source clock to 80 MHz and empties the block
// ---------------------------------------------------------------------------
module spi_clock_divider_search #(
  parameter int PRESCALE_WIDTH = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scd_pkg::SRC_W-1:0]        source_clock_hz,
  // request
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [scd_pkg::TGT_W-1:0]        target_freq,
  // result
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             use_sysclk,
  output logic [scd_pkg::SRC_W-1:0]        achieved_freq,
  output logic [scd_pkg::DIV_CODE_W-1:0]   divisor,
  output logic [PRESCALE_WIDTH-1:0]        prescale_minus_one,
  output logic [2:0]                       count_period,
  output logic                             count_high,
  output logic                             prescale_overflow
);
  import scd_pkg::*;

  localparam logic [DIV_CODE_W-1:0] D_NONE = 3'd0;
  localparam logic [DIV_CODE_W-1:0] D_TWO  = 3'd2;
  localparam logic [DIV_CODE_W-1:0] D_THREE = 3'd3;
  localparam logic [DIV_CODE_W-1:0] D_FIVE = 3'd5;

  // largest prescaler-minus-one that fits the field
  localparam logic [DIVIDEND_W-1:0] PMAX =
    DIVIDEND_W'((64'd1 << PRESCALE_WIDTH) - 64'd1);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_DIV_N     = 7'b0000010,  // s / (t + 1)
    ST_DIV_START = 7'b0000100,  // s / (t * d)
    ST_DIV_PMIN  = 7'b0001000,  // (nmin + d - 1) / d
    ST_DIV_RATE  = 7'b0010000,  // s / (p * d)
    ST_PICK      = 7'b0100000,  // choose divisor, saturate prescaler
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SRC_W-1:0]      src_clk;
  logic [SRC_W-1:0]      t_reg;
  logic [DIV_CODE_W-1:0] d_code;
  logic [DIVIDEND_W-1:0] nmin;
  logic [DIVIDEND_W-1:0] start_p;
  logic [DIVIDEND_W-1:0] p_cur;
  logic [DIVIDEND_W-1:0] p2, p3, p5;
  logic [SRC_W-1:0]      f2, f3, f5;
  logic                  div_go;
  logic                  go_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  req_acc;
  logic                  at_sysclk;
  logic [DIVIDEND_W-1:0] q;
  logic [DIVIDEND_W-1:0] start_fix;
  logic [DIVIDEND_W-1:0] p_pick;

  // selection made in ST_PICK
  logic [DIV_CODE_W-1:0] sel_d;
  logic [SRC_W-1:0]      sel_f;
  logic [DIVIDEND_W-1:0] sel_p;
  logic [DIVIDEND_W-1:0] sel_pm1;
  logic                  sel_ovf;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_DONE);
  assign req_acc   = req_valid && !req_stall;
  assign at_sysclk = (target_freq >= TGT_W'(src_clk));
  assign q         = div_rsp.quotient;

  // start prescaler is at least one, and one for a zero target
  assign start_fix = ((t_reg == '0) || (q == '0)) ? DIVIDEND_W'(1) : q;
  assign p_pick    = (start_p > q) ? start_p : q;

  // ---- shared divider operands, selected by the current step
  always_comb begin
    div_req.go       = div_go;
    div_req.dividend = DIVIDEND_W'(src_clk);
    div_req.divisor  = DIVISOR_W'(t_reg) + DIVISOR_W'(1);
    unique case (state)
      ST_DIV_N: begin
      end
      ST_DIV_START: begin
        div_req.divisor = DIVISOR_W'(t_reg) * DIVISOR_W'(d_code);
      end
      ST_DIV_PMIN: begin
        div_req.dividend = nmin + DIVIDEND_W'(d_code) - DIVIDEND_W'(1);
        div_req.divisor  = DIVISOR_W'(d_code);
      end
      ST_DIV_RATE: begin
        div_req.divisor = DIVISOR_W'(p_cur) * DIVISOR_W'(d_code);
      end
      default: begin
      end
    endcase
  end

  scd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) state_next = at_sysclk ? ST_DONE : ST_DIV_N;
      end
      ST_DIV_N: begin
        if (div_rsp.done) state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        if (div_rsp.done) state_next = ST_DIV_PMIN;
      end
      ST_DIV_PMIN: begin
        if (div_rsp.done) state_next = ST_DIV_RATE;
      end
      ST_DIV_RATE: begin
        if (div_rsp.done) begin
          // divisor 2 hitting the target exactly ends the search early
          if ((d_code == D_FIVE) || ((d_code == D_TWO) && (q[SRC_W-1:0] == t_reg))) begin
            state_next = ST_PICK;
          end else begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_PICK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // every entry into a division step launches the divider once
  assign go_next = (state_next != state) &&
                   ((state_next == ST_DIV_N) || (state_next == ST_DIV_START) ||
                    (state_next == ST_DIV_PMIN) || (state_next == ST_DIV_RATE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_go  <= 1'b0;
      src_clk <= SRC_W'(80000000);
    end else begin
      state  <= state_next;
      div_go <= go_next;
      if (cfg_valid && cfg_ready) src_clk <= source_clock_hz;
    end
  end

  // ---- search data path
  always_ff @(posedge clk) begin
    if (req_acc) begin
      t_reg  <= target_freq[SRC_W-1:0];
      d_code <= D_TWO;
    end
    if (div_rsp.done) begin
      unique case (state)
        ST_DIV_N:     nmin    <= q + DIVIDEND_W'(1);
        ST_DIV_START: start_p <= start_fix;
        ST_DIV_PMIN:  p_cur   <= p_pick;
        ST_DIV_RATE: begin
          unique case (d_code)
            D_TWO: begin
              f2     <= q[SRC_W-1:0];
              p2     <= p_cur;
              d_code <= D_THREE;
            end
            D_THREE: begin
              f3     <= q[SRC_W-1:0];
              p3     <= p_cur;
              d_code <= D_FIVE;
            end
            default: begin
              f5 <= q[SRC_W-1:0];
              p5 <= p_cur;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // ---- divisor choice: 2 unless 3 or 5 is strictly faster, 5 wins a tie with 3
  always_comb begin
    priority if ((f2 == t_reg) || !((f3 > f2) || (f5 > f2))) begin
      sel_d = D_TWO;
      sel_f = f2;
      sel_p = p2;
    end else if (f3 > f5) begin
      sel_d = D_THREE;
      sel_f = f3;
      sel_p = p3;
    end else begin
      sel_d = D_FIVE;
      sel_f = f5;
      sel_p = p5;
    end
    sel_pm1 = sel_p - DIVIDEND_W'(1);
    sel_ovf = (sel_pm1 > PMAX);
  end

  // ---- result word register
  always_ff @(posedge clk) begin
    if (req_acc && at_sysclk) begin
      use_sysclk         <= 1'b1;
      achieved_freq      <= src_clk;
      divisor            <= D_NONE;
      prescale_minus_one <= '0;
      count_period       <= 3'd0;
      count_high         <= 1'b0;
      prescale_overflow  <= 1'b0;
    end else if (state == ST_PICK) begin
      use_sysclk         <= 1'b0;
      achieved_freq      <= sel_f;
      divisor            <= sel_d;
      prescale_minus_one <= sel_ovf ? {PRESCALE_WIDTH{1'b1}}
                                    : sel_pm1[PRESCALE_WIDTH-1:0];
      count_period       <= 3'(sel_d - DIV_CODE_W'(1));
      count_high         <= sel_d[2];  // floor(d/2)-1 is odd only for divisor 5
      prescale_overflow  <= sel_ovf;
    end
  end

  a_launch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (target_freq < TGT_W'(src_clk))) |=>
      (state == ST_DIV_N && div_go))
    else $error("divided request did not start the search");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !use_sysclk) |-> (achieved_freq <= t_reg))
    else $error("achieved rate above the requested rate");
  a_codes: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !use_sysclk) |->
      ((divisor == D_TWO || divisor == D_THREE || divisor == D_FIVE) &&
       (count_period == 3'(divisor - DIV_CODE_W'(1)))))
    else $error("divisor and counter fields disagree");

endmodule
